@@ design/newton_fractal_pixel_defines.svh @@
// ----------------------------------------------------------------------------
// Newton fractal pixel assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEWTON_FRACTAL_PIXEL_DEFINES_SVH
`define NEWTON_FRACTAL_PIXEL_DEFINES_SVH
`ifndef SYNTHESIS
`define NFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("newton_fractal_pixel assertion failed");
`define NFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("newton_fractal_pixel assertion failed");
`else
`define NFP_ASSERT_IMP(lbl, ante, cons)
`define NFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/nfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Newton fractal pixel package
// Field widths, register indexes, fixed-point constants and sequencer states.
// ----------------------------------------------------------------------------
package nfp_pkg;

  localparam int COORD_W = 12;
  localparam int ITER_W  = 16;
  localparam int ROOT_W  = 2;
  localparam int PAL_W   = 8;
  localparam int ADDR_W  = 24;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int Z_W     = 46;
  localparam int OP_W    = 33;
  localparam int NUM_W   = 60;
  localparam int DEN_W   = 35;
  localparam int DCNT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd5;

  localparam logic signed [Z_W-1:0] TWO_Z   = 46'sd536870912;
  localparam logic signed [Z_W-1:0] THREE_Z = 46'sd805306368;
  localparam logic signed [63:0] FOUR_Q56   = 64'sd288230376151711744;
  localparam logic signed [63:0] SMALL_Q56  = 64'sd4503599627370496;
  localparam logic signed [63:0] EPS_SQ_Q56 = 64'sd720575940;
  localparam logic signed [63:0] DEGEN_Q56  = 64'sd24019;
  localparam logic signed [OP_W-1:0] ONE_OP     = 33'sd268435456;
  localparam logic signed [OP_W-1:0] HALF_OP    = 33'sd134217728;
  localparam logic signed [OP_W-1:0] SQRT3_2_OP = 33'sd232471924;
  localparam logic signed [OP_W-1:0] RECIP3_OP  = 33'sd2863311531;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_MOD      = 20'h00002,
    S_INIT_X   = 20'h00004,
    S_INIT_Y   = 20'h00008,
    S_INIT_A   = 20'h00010,
    S_CHECK    = 20'h00020,
    S_MUL_XX   = 20'h00040,
    S_MUL_YY   = 20'h00080,
    S_TEST_MAG = 20'h00100,
    S_ROOT_DX  = 20'h00200,
    S_ROOT_DY  = 20'h00400,
    S_DEGEN    = 20'h00800,
    S_MUL_XY   = 20'h01000,
    S_MUL_AA   = 20'h02000,
    S_MUL_BB   = 20'h04000,
    S_DIV_LOAD = 20'h08000,
    S_DIV_RUN  = 20'h10000,
    S_DIV_END  = 20'h20000,
    S_PAL_RED  = 20'h40000,
    S_DONE     = 20'h80000
  } state_t;

endpackage

@@ design/nfp_in_if.sv @@
// ----------------------------------------------------------------------------
// Newton fractal pixel input channel
// Valid/ready channel carrying one pixel column and row per transfer.
// ----------------------------------------------------------------------------
interface nfp_in_if
  import nfp_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

@@ design/nfp_out_if.sv @@
// ----------------------------------------------------------------------------
// Newton fractal pixel result channel
// Valid/ready channel carrying one pixel result per transfer.
// ----------------------------------------------------------------------------
interface nfp_out_if
  import nfp_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              converged;
  logic [ROOT_W-1:0] root_index;
  logic [ITER_W-1:0] iterations;
  logic [PAL_W-1:0]  palette_index;
  logic [ADDR_W-1:0] pixel_address;

  modport source (output valid, output converged, output root_index, output iterations,
                  output palette_index, output pixel_address, input ready);
  modport sink   (input valid, input converged, input root_index, input iterations,
                  input palette_index, input pixel_address, output ready);
endinterface

@@ design/newton_fractal_pixel.sv @@
// ----------------------------------------------------------------------------
// Newton fractal pixel
// Newton iteration for z^3 - 1 on one pixel in fixed point, with one shared
// multiplier and one shared bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
// Usage: a pixel (column, row) is taken on in_ch when in_ch.ready is high,
// which holds only while the sequencer is idle. One result per pixel leaves
// on out_ch through an output register. Configuration is written on
// cfg_we/cfg_index/cfg_data while no pixel is in flight.
// The coordinates are first reduced below MAX_SIDE by repeated
// subtraction, the setup states S_INIT_X, S_INIT_Y and S_INIT_A follow,
// then each full Newton pass runs the shared multiplier work and tests,
// two divisions by 3 done by reciprocal multiply, and two divisions by 3m
// on the shared restoring divider. A pass may stop before its divisions,
// a root adds palette reduction, and the output register is then loaded.
// A new pixel is taken only once the last result is in the output
// register. When the receiver stalls the result holds and the sequencer
// waits in its final state until the output register frees. Reset loads
// the register defaults and empties the output register.
// ----------------------------------------------------------------------------
`include "newton_fractal_pixel_defines.svh"

module newton_fractal_pixel
  import nfp_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_SIDE        = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nfp_in_if.sink               in_ch,
  nfp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [8:0]  PAL_N = 9'(PALETTE_ENTRIES);
  localparam logic [12:0] SIDE_N = 13'(MAX_SIDE);

  state_t state_r, state_nxt;

  logic signed [31:0] origin_x_r, origin_y_r;
  logic [30:0]        step_x_r, step_y_r;
  logic [ITER_W-1:0]  max_iter_r;
  logic [12:0]        image_width_r;

  logic [COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic signed [Z_W-1:0] x_r, x_nxt, y_r, y_nxt, xn_r, xn_nxt, yn_r, yn_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic [8:0]         pal_r, pal_nxt;
  logic               found_r, found_nxt;
  logic [ROOT_W-1:0]  k_r, k_nxt;
  logic signed [63:0] xx_r, xx_nxt, yy_r, yy_nxt, mag_r, mag_nxt, t_r, t_nxt;
  logic signed [63:0] xy_r, xy_nxt, aa_r, aa_nxt;
  logic signed [OP_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [DEN_W-1:0]   m_r, m_nxt;
  logic [1:0]         dsel_r, dsel_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_conv_r;
  logic [ROOT_W-1:0]  out_root_r;
  logic [ITER_W-1:0]  out_iter_r;
  logic [PAL_W-1:0]   out_pal_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_load;

  logic signed [OP_W-1:0]   mul_a, mul_b, xs, ys, dx, dy;
  logic signed [2*OP_W-1:0] prod;
  logic signed [63:0]       prod64, dist_sq, num;
  logic [63:0]              num_abs;
  logic [DEN_W:0]           rem_sh;
  logic signed [Z_W-1:0]    q;
  logic [3:0]               k5;

  function automatic logic signed [63:0] rshr28(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : v;
    r = (mag + 64'd134217728) >> 28;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [OP_W-1:0] root_re(input logic [ROOT_W-1:0] k);
    return (k == 2'd0) ? ONE_OP : -HALF_OP;
  endfunction

  function automatic logic signed [OP_W-1:0] root_im(input logic [ROOT_W-1:0] k);
    logic signed [OP_W-1:0] r;
    case (k)
      2'd1:    r = SQRT3_2_OP;
      2'd2:    r = -SQRT3_2_OP;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign xs = x_r[OP_W-1:0];
  assign ys = y_r[OP_W-1:0];
  assign dx = xs - root_re(k_r);
  assign dy = ys - root_im(k_r);

  always_comb begin
    case (state_r)
      S_INIT_X:   begin mul_a = {21'b0, col_r}; mul_b = {2'b0, step_x_r}; end
      S_INIT_Y:   begin mul_a = {21'b0, row_r}; mul_b = {2'b0, step_y_r}; end
      S_INIT_A:   begin mul_a = {21'b0, row_r}; mul_b = {20'b0, image_width_r}; end
      S_MUL_XX:   begin mul_a = xs; mul_b = xs; end
      S_MUL_YY:   begin mul_a = ys; mul_b = ys; end
      S_ROOT_DX:  begin mul_a = dx; mul_b = dx; end
      S_ROOT_DY:  begin mul_a = dy; mul_b = dy; end
      S_MUL_XY:   begin mul_a = xs; mul_b = ys; end
      S_MUL_AA:   begin mul_a = a_r; mul_b = a_r; end
      S_MUL_BB:   begin mul_a = b_r; mul_b = b_r; end
      S_DIV_LOAD: begin mul_a = OP_W'(num_abs + 64'd1); mul_b = RECIP3_OP; end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod64  = prod[63:0];
  assign dist_sq = t_r + prod64;
  assign k5      = {k_r, 2'b00} + {2'b00, k_r};
  assign rem_sh  = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign q       = neg_r ? -$signed(quo_r[Z_W-1:0]) : $signed(quo_r[Z_W-1:0]);

  always_comb begin
    case (dsel_r)
      2'd0:    num = 64'($signed({x_r, 1'b0}));
      2'd1:    num = 64'(a_r) <<< 28;
      2'd2:    num = 64'($signed({y_r, 1'b0}));
      default: num = 64'(b_r) <<< 28;
    endcase
    num_abs = num[63] ? 64'(-num) : num;
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    row_nxt = row_r;
    x_nxt = x_r;
    y_nxt = y_r;
    xn_nxt = xn_r;
    yn_nxt = yn_r;
    addr_nxt = addr_r;
    iter_nxt = iter_r;
    pal_nxt = pal_r;
    found_nxt = found_r;
    k_nxt = k_r;
    xx_nxt = xx_r;
    yy_nxt = yy_r;
    mag_nxt = mag_r;
    t_nxt = t_r;
    xy_nxt = xy_r;
    aa_nxt = aa_r;
    a_nxt = a_r;
    b_nxt = b_r;
    m_nxt = m_r;
    dsel_nxt = dsel_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    dcnt_nxt = dcnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          col_nxt = in_ch.column;
          row_nxt = in_ch.row;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if ({1'b0, col_r} >= SIDE_N) begin
          col_nxt = COORD_W'({1'b0, col_r} - SIDE_N);
        end
        if ({1'b0, row_r} >= SIDE_N) begin
          row_nxt = COORD_W'({1'b0, row_r} - SIDE_N);
        end
        if ({1'b0, col_r} < SIDE_N && {1'b0, row_r} < SIDE_N) begin
          state_nxt = S_INIT_X;
        end
      end
      S_INIT_X: begin
        x_nxt = Z_W'(origin_x_r) + prod64[Z_W-1:0];
        state_nxt = S_INIT_Y;
      end
      S_INIT_Y: begin
        y_nxt = Z_W'(origin_y_r) - prod64[Z_W-1:0];
        state_nxt = S_INIT_A;
      end
      S_INIT_A: begin
        addr_nxt = prod64[ADDR_W-1:0] + {12'b0, col_r};
        iter_nxt = '0;
        pal_nxt = '0;
        found_nxt = 1'b0;
        k_nxt = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (iter_r >= max_iter_r || x_r > TWO_Z || x_r < -TWO_Z ||
            y_r > TWO_Z || y_r < -TWO_Z) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL_XX;
        end
      end
      S_MUL_XX: begin
        xx_nxt = prod64;
        state_nxt = S_MUL_YY;
      end
      S_MUL_YY: begin
        yy_nxt = prod64;
        state_nxt = S_TEST_MAG;
      end
      S_TEST_MAG: begin
        mag_nxt = xx_r + yy_r;
        k_nxt = '0;
        if (xx_r + yy_r > FOUR_Q56) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ROOT_DX;
        end
      end
      S_ROOT_DX: begin
        t_nxt = prod64;
        state_nxt = S_ROOT_DY;
      end
      S_ROOT_DY: begin
        if (dist_sq <= EPS_SQ_Q56) begin
          found_nxt = 1'b1;
          pal_nxt = pal_r + {5'b0, k5};
          state_nxt = S_PAL_RED;
        end else if (k_r == 2'd2) begin
          state_nxt = S_DEGEN;
        end else begin
          k_nxt = k_r + 2'd1;
          state_nxt = S_ROOT_DX;
        end
      end
      S_DEGEN: begin
        if (mag_r <= DEGEN_Q56) begin
          state_nxt = S_DONE;
        end else begin
          iter_nxt = iter_r + 16'd1;
          pal_nxt = (pal_r + 9'd1 >= PAL_N) ? '0 : pal_r + 9'd1;
          if (mag_r < SMALL_Q56) begin
            x_nxt = THREE_Z;
            y_nxt = '0;
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_MUL_XY;
          end
        end
      end
      S_MUL_XY: begin
        xy_nxt = prod64;
        a_nxt = OP_W'(rshr28(xx_r - yy_r));
        state_nxt = S_MUL_AA;
      end
      S_MUL_AA: begin
        aa_nxt = prod64;
        b_nxt = OP_W'(rshr28(xy_r <<< 1));
        state_nxt = S_MUL_BB;
      end
      S_MUL_BB: begin
        m_nxt = DEN_W'(rshr28(aa_r + prod64));
        dsel_nxt = '0;
        state_nxt = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        if (m_r == '0) begin
          x_nxt = THREE_Z;
          y_nxt = '0;
          state_nxt = S_CHECK;
        end else if (!dsel_r[0]) begin
          quo_nxt = NUM_W'(prod[2*OP_W-1:OP_W]);
          neg_nxt = num[63];
          state_nxt = S_DIV_END;
        end else begin
          den_nxt = DEN_W'({m_r, 1'b0} + {1'b0, m_r});
          quo_nxt = num_abs[NUM_W-1:0] +
                    NUM_W'(DEN_W'({m_r, 1'b0} + {1'b0, m_r}) >> 1);
          rem_nxt = '0;
          neg_nxt = num[63];
          dcnt_nxt = DCNT_W'(NUM_W);
          state_nxt = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = S_DIV_END;
        end
      end
      S_DIV_END: begin
        dsel_nxt = dsel_r + 2'd1;
        state_nxt = S_DIV_LOAD;
        case (dsel_r)
          2'd0: xn_nxt = q;
          2'd1: xn_nxt = xn_r + q;
          2'd2: yn_nxt = q;
          default: begin
            x_nxt = xn_r;
            y_nxt = yn_r - q;
            state_nxt = S_CHECK;
          end
        endcase
      end
      S_PAL_RED: begin
        if (pal_r >= PAL_N) begin
          pal_nxt = pal_r - PAL_N;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      origin_x_r    <= -32'sd536870912;
      origin_y_r    <= 32'sd536870912;
      step_x_r      <= 31'd262144;
      step_y_r      <= 31'd262144;
      max_iter_r    <= 16'd64;
      image_width_r <= 13'd1024;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X:    origin_x_r    <= $signed(cfg_data);
          CFG_ORIGIN_Y:    origin_y_r    <= $signed(cfg_data);
          CFG_STEP_X:      step_x_r      <= cfg_data[30:0];
          CFG_STEP_Y:      step_y_r      <= cfg_data[30:0];
          CFG_MAX_ITER:    max_iter_r    <= cfg_data[ITER_W-1:0];
          CFG_IMAGE_WIDTH: image_width_r <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    xn_r    <= xn_nxt;
    yn_r    <= yn_nxt;
    addr_r  <= addr_nxt;
    iter_r  <= iter_nxt;
    pal_r   <= pal_nxt;
    found_r <= found_nxt;
    k_r     <= k_nxt;
    xx_r    <= xx_nxt;
    yy_r    <= yy_nxt;
    mag_r   <= mag_nxt;
    t_r     <= t_nxt;
    xy_r    <= xy_nxt;
    aa_r    <= aa_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    m_r     <= m_nxt;
    dsel_r  <= dsel_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    neg_r   <= neg_nxt;
    dcnt_r  <= dcnt_nxt;
    if (out_load) begin
      out_conv_r <= found_r;
      out_root_r <= found_r ? k_r : '0;
      out_iter_r <= iter_r;
      out_pal_r  <= found_r ? pal_r[PAL_W-1:0] : '0;
      out_addr_r <= addr_r;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.converged     = out_conv_r;
  assign out_ch.root_index    = out_root_r;
  assign out_ch.iterations    = out_iter_r;
  assign out_ch.palette_index = out_pal_r;
  assign out_ch.pixel_address = out_addr_r;

  `NFP_ASSERT_NXT(a_accept_reduces, in_ch.valid && in_ch.ready, state_r == S_MOD)
  `NFP_ASSERT_IMP(a_no_root_clean, out_valid_r && !out_conv_r, out_root_r == '0 && out_pal_r == '0)
  `NFP_ASSERT_IMP(a_root_range, out_valid_r && out_conv_r, out_root_r != 2'd3)
  `NFP_ASSERT_IMP(a_iter_limit, out_valid_r, out_iter_r <= max_iter_r)

endmodule

@@ bench/tb_nfp_channels.sv @@
// ----------------------------------------------------------------------------
// Testbench channel helpers
// Holds the record types shared by the driver and monitor of the bench.
// ----------------------------------------------------------------------------
package tb_nfp_types;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic        converged;
    logic [1:0]  root_index;
    logic [15:0] iterations;
    logic [7:0]  palette_index;
    logic [23:0] pixel_address;
  } shade_t;

endpackage

@@ bench/tb_newton_fractal_pixel.sv @@
// ----------------------------------------------------------------------------
// Newton fractal pixel testbench
// Drives pixels through the input channel under bursty traffic, predicts each
// fixed-point Newton result, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_newton_fractal_pixel;
  import nfp_pkg::*;
  import tb_nfp_types::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  nfp_in_if in_ch ();
  nfp_out_if out_ch ();

  newton_fractal_pixel u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  longint org_x, org_y, inc_x, inc_y;
  int unsigned iter_cap, row_pitch;

  pixel_t pending_pixels[$];
  shade_t expected_shades[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  function automatic longint round_shift28(longint v);
    if (v < 0) return -((-v + (64'sd1 <<< 27)) >>> 28);
    return (v + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n < 0) return -((-n + d / 2) / d);
    return (n + d / 2) / d;
  endfunction

  function automatic shade_t newton_shade(pixel_t p);
    shade_t s;
    longint x, y, mag2, a, b, m, dx, dy;
    longint rre[3], rim[3];
    int unsigned steps;
    bit hit;
    int k;
    rre[0] = 268435456; rre[1] = -134217728; rre[2] = -134217728;
    rim[0] = 0; rim[1] = 232471924; rim[2] = -232471924;
    x = org_x + longint'(p.column) * inc_x;
    y = org_y - longint'(p.row) * inc_y;
    steps = 0;
    hit = 1'b0;
    k = 0;
    while (steps < iter_cap && !hit) begin
      if (x > 536870912 || x < -536870912 || y > 536870912 || y < -536870912) break;
      mag2 = x * x + y * y;
      if (mag2 > FOUR_Q56) break;
      for (int r = 0; r < 3; r++) begin
        dx = x - rre[r];
        dy = y - rim[r];
        if (!hit && dx * dx + dy * dy <= EPS_SQ_Q56) begin
          hit = 1'b1;
          k = r;
        end
      end
      if (hit) break;
      if (mag2 <= DEGEN_Q56) break;
      steps++;
      if (mag2 < SMALL_Q56) begin
        x = 805306368;
        y = 0;
        continue;
      end
      a = round_shift28(x * x - y * y);
      b = round_shift28(2 * x * y);
      m = round_shift28(a * a + b * b);
      if (m <= 0) begin
        x = 805306368;
        y = 0;
        continue;
      end
      x = round_div(2 * x, 3) + round_div(a * 268435456, 3 * m);
      y = round_div(2 * y, 3) - round_div(b * 268435456, 3 * m);
    end
    s.converged = hit;
    s.root_index = hit ? 2'(k) : 2'd0;
    s.iterations = 16'(steps);
    s.palette_index = hit ? 8'(k * 5 + steps) : 8'd0;
    s.pixel_address = 24'(longint'(p.row) * row_pitch + p.column);
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: org_x = longint'(signed'(val));
      CFG_ORIGIN_Y: org_y = longint'(signed'(val));
      CFG_STEP_X: inc_x = longint'(val[30:0]);
      CFG_STEP_Y: inc_y = longint'(val[30:0]);
      CFG_MAX_ITER: iter_cap = val[15:0];
      CFG_IMAGE_WIDTH: row_pitch = val[12:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_pixels.size() != 0 || expected_shades.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_pixel(input int c, input int r);
    pixel_t p;
    p.column = 12'(c);
    p.row = 12'(r);
    pending_pixels.push_back(p);
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.column <= '0;
      in_ch.row <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_shades.push_back(newton_shade({in_ch.column, in_ch.row}));
        void'(pending_pixels.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        pixel_t nx;
        nx = pending_pixels[0];
        in_ch.valid <= 1'b1;
        in_ch.column <= nx.column;
        in_ch.row <= nx.row;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(1, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor with a receiver stall pattern of its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_shades.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          shade_t e;
          e = expected_shades.pop_front();
          if (out_ch.converged !== e.converged) begin
            $error("converged: expected %0d actual %0d", e.converged, out_ch.converged);
            errors++;
          end
          if (out_ch.root_index !== e.root_index) begin
            $error("root_index: expected %0d actual %0d", e.root_index, out_ch.root_index);
            errors++;
          end
          if (out_ch.iterations !== e.iterations) begin
            $error("iterations: expected %0d actual %0d", e.iterations, out_ch.iterations);
            errors++;
          end
          if (out_ch.palette_index !== e.palette_index) begin
            $error("palette_index: expected %0d actual %0d", e.palette_index,
                   out_ch.palette_index);
            errors++;
          end
          if (out_ch.pixel_address !== e.pixel_address) begin
            $error("pixel_address: expected %0d actual %0d", e.pixel_address,
                   out_ch.pixel_address);
            errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 1000;
      if (stall_phase < 300) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0) ? 1'b1 : ($urandom_range(0, 40) == 0);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    org_x = -536870912; org_y = 536870912;
    inc_x = 262144; inc_y = 262144;
    iter_cap = 64; row_pitch = 1024;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: the four corners and interior points at reset settings.
    queue_pixel(0, 0); queue_pixel(4095, 4095); queue_pixel(512, 512);
    queue_pixel(4095, 0); queue_pixel(0, 4095); queue_pixel(1536, 512);
    queue_pixel(1000, 300); queue_pixel(100, 700);
    drain();
    // Start exactly on root 0 and on the upper complex root.
    write_reg(CFG_ORIGIN_X, 32'd268435456);
    write_reg(CFG_ORIGIN_Y, 32'd0);
    write_reg(CFG_STEP_X, 32'd0);
    write_reg(CFG_STEP_Y, 32'd0);
    queue_pixel(5, 9);
    drain();
    write_reg(CFG_ORIGIN_X, -32'sd134217728);
    write_reg(CFG_ORIGIN_Y, 32'd232471924);
    queue_pixel(1, 1);
    drain();
    // Near zero: degenerate and small-z escapes.
    write_reg(CFG_ORIGIN_X, 32'd0);
    write_reg(CFG_ORIGIN_Y, 32'd0);
    queue_pixel(0, 0);
    drain();
    write_reg(CFG_ORIGIN_X, 32'd1000000);
    queue_pixel(0, 0);
    drain();
    // Extremes of every register, max_iter zero and wide pitches.
    write_reg(CFG_ORIGIN_X, 32'h8000_0000);
    write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(CFG_STEP_X, 32'h7FFF_FFFF);
    write_reg(CFG_STEP_Y, 32'h7FFF_FFFF);
    write_reg(CFG_MAX_ITER, 32'd0);
    write_reg(CFG_IMAGE_WIDTH, 32'd4096);
    queue_pixel(4095, 4095); queue_pixel(0, 0); queue_pixel(1, 4095);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 32'd0);
    write_reg(CFG_MAX_ITER, 32'd65535);
    write_reg(CFG_ORIGIN_X, 32'd0);
    write_reg(CFG_ORIGIN_Y, 32'd0);
    write_reg(CFG_STEP_X, 32'd1000);
    write_reg(CFG_STEP_Y, 32'd1000);
    queue_pixel(4095, 4095); queue_pixel(2048, 17);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 32'h1FFF);
    queue_pixel(7, 4095);
    drain();

    // Random phases: the view mostly frames the interesting region.
    for (int ph = 0; ph < 14; ph++) begin
      int pick;
      pick = $urandom_range(0, 5);
      write_reg(CFG_ORIGIN_X, (pick == 0) ? $urandom : -32'sd536870912 -
                $urandom_range(0, 100000000));
      write_reg(CFG_ORIGIN_Y, (pick == 0) ? $urandom : 32'sd536870912 +
                $urandom_range(0, 100000000));
      write_reg(CFG_STEP_X, (pick == 1) ? ($urandom & 32'h7FFF_FFFF) :
                $urandom_range(1, 2000000) >> $urandom_range(0, 10));
      write_reg(CFG_STEP_Y, (pick == 1) ? ($urandom & 32'h7FFF_FFFF) :
                $urandom_range(1, 2000000) >> $urandom_range(0, 10));
      write_reg(CFG_MAX_ITER, (pick == 2) ? $urandom_range(0, 3) :
                ((pick == 3) ? 65535 : $urandom_range(4, 80)));
      write_reg(CFG_IMAGE_WIDTH, (pick == 4) ? $urandom_range(0, 8191) :
                $urandom_range(1, 4096));
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 9) == 0) queue_pixel($urandom_range(0, 4095),
                                                   $urandom_range(0, 4095));
        else queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
